@@ design/cnm_pkg.sv @@
// shared types and constants for the cross neighbor marker
package cnm_pkg;

  // field widths and defaults
  localparam int MAX_SIDE_DEF = 32;
  localparam int SIDE_W       = 6;
  localparam int ROW_W        = 5;
  localparam int COL_W        = 5;
  localparam int CLASS_W      = 2;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd32;

  // cell class codes
  typedef enum logic [CLASS_W-1:0] {
    CLS_EMPTY   = 2'd0,
    CLS_BLOCKER = 2'd1,
    CLS_MARKED  = 2'd2
  } cnm_class_e;

  // controller states
  typedef enum logic [0:0] {
    ST_RUN   = 1'b0,
    ST_FLUSH = 1'b1
  } cnm_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic cfg_write;
    logic accept;
    logic flush;
  } cnm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;
    logic row_end;
    logic last_row;
  } cnm_sts_t;

endpackage

@@ design/cnm_ctrl.sv @@
// controller state machine: request acceptance and last row flush sequencing
module cnm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  cnm_pkg::cnm_sts_t  sts_i,
  output cnm_pkg::cnm_cmd_t  cmd_o
);

  cnm_pkg::cnm_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cnm_pkg::ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cfg_ready_o   = 1'b0;
    cmd_o         = '0;
    case (state_q)
      cnm_pkg::ST_RUN: begin
        cfg_ready_o = 1'b1;
        // a register write takes precedence over a cell request
        in_ready_o  = sts_i.slot_free && !cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.cfg_write = 1'b1;
        end else if (in_valid_i && sts_i.slot_free) begin
          cmd_o.accept = 1'b1;
          if (sts_i.row_end && sts_i.last_row) begin
            state_d = cnm_pkg::ST_FLUSH;
          end
        end
      end
      cnm_pkg::ST_FLUSH: begin
        // one last row cell per free output slot
        if (sts_i.slot_free) begin
          cmd_o.flush = 1'b1;
          if (sts_i.row_end) begin
            state_d = cnm_pkg::ST_RUN;
          end
        end
      end
      default: begin
        state_d = cnm_pkg::ST_RUN;
      end
    endcase
  end

endmodule

@@ design/cnm_datapath.sv @@
// datapath: row stores, position counters, classifier and output register
module cnm_datapath #(
  parameter int MaxSide = cnm_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cnm_pkg::cnm_cmd_t             cmd_i,
  output cnm_pkg::cnm_sts_t             sts_o,
  input  logic                          is_marked_i,
  input  logic [cnm_pkg::SIDE_W-1:0]    cfg_grid_side_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [cnm_pkg::CLASS_W-1:0]   cell_class_o,
  output logic [cnm_pkg::ROW_W-1:0]     cell_row_o,
  output logic [cnm_pkg::COL_W-1:0]     cell_col_o,
  output logic                          frame_end_o,
  output logic                          run_last_o
);

  localparam int SW = $clog2(MaxSide + 1);
  localparam int IW = (MaxSide > 1) ? $clog2(MaxSide) : 1;

  logic [cnm_pkg::SIDE_W-1:0] side_q;
  logic [MaxSide-1:0]         two_up_q, one_up_q, now_q, now_set;
  logic [SW-1:0]              row_q, col_q;
  logic [SW-1:0]              side_eff, side_m1, col_m1, col_p1, row_m1;
  logic                       out_valid_q;
  logic [cnm_pkg::CLASS_W-1:0] class_q;
  logic [cnm_pkg::ROW_W-1:0]  row_out_q;
  logic [cnm_pkg::COL_W-1:0]  col_out_q;
  logic                       frame_end_q, run_last_q;

  logic [MaxSide-1:0]         mid_row;
  logic                       up_bit, down_bit, left_bit, right_bit, self_bit;
  logic [IW-1:0]              idx;
  cnm_pkg::cnm_class_e        cls;
  logic                       row_end, last_row, load_out;

  // effective side: zero acts as one, clamp to the maximum
  always_comb begin
    if (side_q == '0) begin
      side_eff = SW'(1);
    end else if (int'(side_q) > MaxSide) begin
      side_eff = SW'(MaxSide);
    end else begin
      side_eff = SW'(side_q);
    end
  end

  assign side_m1  = side_eff - 1'b1;
  assign row_end  = (col_q == side_m1);
  assign last_row = (row_q == side_m1);
  assign col_m1   = col_q - 1'b1;
  assign col_p1   = col_q + 1'b1;
  assign row_m1   = row_q - 1'b1;
  assign idx      = col_q[IW-1:0];

  // incoming cell merged into the row being filled
  always_comb begin
    now_set      = now_q;
    now_set[idx] = now_q[idx] | is_marked_i;
  end

  // neighborhood select: above row during streaming, last row during flush
  always_comb begin
    if (cmd_i.flush) begin
      mid_row  = now_q;
      up_bit   = one_up_q[idx];
      down_bit = 1'b0;
    end else begin
      mid_row  = one_up_q;
      up_bit   = two_up_q[idx];
      down_bit = now_set[idx];
    end
    self_bit  = mid_row[idx];
    left_bit  = (col_q != '0) && mid_row[col_m1[IW-1:0]];
    right_bit = (col_p1 < side_eff) && mid_row[col_p1[IW-1:0]];
    if (self_bit) begin
      cls = cnm_pkg::CLS_MARKED;
    end else if (up_bit || down_bit || left_bit || right_bit) begin
      cls = cnm_pkg::CLS_BLOCKER;
    end else begin
      cls = cnm_pkg::CLS_EMPTY;
    end
  end

  assign load_out = (cmd_i.accept && (row_q != '0)) || cmd_i.flush;

  // frame state, counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= cnm_pkg::SIDE_RESET;
      two_up_q    <= '0;
      one_up_q    <= '0;
      now_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.cfg_write) begin
        side_q   <= cfg_grid_side_i;
        two_up_q <= '0;
        one_up_q <= '0;
        now_q    <= '0;
        row_q    <= '0;
        col_q    <= '0;
      end else if (cmd_i.accept) begin
        if (row_end && !last_row) begin
          two_up_q <= one_up_q;
          one_up_q <= now_set;
          now_q    <= '0;
          col_q    <= '0;
          row_q    <= row_q + 1'b1;
        end else if (row_end) begin
          // last cell of the frame: rewind column for the flush
          now_q <= now_set;
          col_q <= '0;
        end else begin
          now_q <= now_set;
          col_q <= col_p1;
        end
      end else if (cmd_i.flush) begin
        if (row_end) begin
          two_up_q <= '0;
          one_up_q <= '0;
          now_q    <= '0;
          row_q    <= '0;
          col_q    <= '0;
        end else begin
          col_q <= col_p1;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      class_q   <= cls;
      col_out_q <= cnm_pkg::COL_W'(col_q);
      if (cmd_i.flush) begin
        row_out_q   <= cnm_pkg::ROW_W'(row_q);
        frame_end_q <= row_end;
        run_last_q  <= row_end;
      end else begin
        row_out_q   <= cnm_pkg::ROW_W'(row_m1);
        frame_end_q <= 1'b0;
        run_last_q  <= !(row_end && last_row);
      end
    end
  end

  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.row_end   = row_end;
  assign sts_o.last_row  = last_row;

  assign out_valid_o  = out_valid_q;
  assign cell_class_o = class_q;
  assign cell_row_o   = row_out_q;
  assign cell_col_o   = col_out_q;
  assign frame_end_o  = frame_end_q;
  assign run_last_o   = run_last_q;

endmodule

@@ design/cross_neighbor_marker_unit.sv @@
// top level of the cross neighbor marker: controller plus datapath
//
// Cells of a square grid arrive in raster order on the in channel, one
// is_marked bit per request. Each cell is classed as marked, blocker
// (empty with a marked cell up, down, left or right) or empty; cells off
// the grid count as empty. A cell's result leaves on the out channel in
// the cycle after the cell directly below it is accepted, so row 0 gives
// nothing until row 1 streams in. The final cell of a frame also starts a
// flush of the whole last row, one result per cycle while the receiver keeps
// up, one per column (grid_side, zero taken as one, values above MaxSide as
// MaxSide), during which no cell and no register write is taken.
// Outside the flush one cell is taken per cycle; the single output
// register lets a new request in whenever the held result leaves in the
// same cycle, so a stalled receiver stalls the in channel.
// The cfg channel writes grid_side and restarts the frame.
// After reset grid_side is 32 and all row stores and counters are clear.
module cross_neighbor_marker_unit #(
  parameter int MaxSide = cnm_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          is_marked_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cnm_pkg::SIDE_W-1:0]    cfg_grid_side_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cnm_pkg::CLASS_W-1:0]   cell_class_o,
  output logic [cnm_pkg::ROW_W-1:0]     cell_row_o,
  output logic [cnm_pkg::COL_W-1:0]     cell_col_o,
  output logic                          frame_end_o,
  output logic                          run_last_o
);

  cnm_pkg::cnm_cmd_t cmd;
  cnm_pkg::cnm_sts_t sts;

  // sequencing
  cnm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and classification
  cnm_datapath #(
    .MaxSide (MaxSide)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .is_marked_i     (is_marked_i),
    .cfg_grid_side_i (cfg_grid_side_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .cell_class_o    (cell_class_o),
    .cell_row_o      (cell_row_o),
    .cell_col_o      (cell_col_o),
    .frame_end_o     (frame_end_o),
    .run_last_o      (run_last_o)
  );

endmodule

@@ design/cnm_checker.sv @@
// port level checks for the cross neighbor marker, bound to the top level
module cnm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        cfg_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [cnm_pkg::CLASS_W-1:0] cell_class_o,
  input logic [cnm_pkg::ROW_W-1:0]   cell_row_o,
  input logic [cnm_pkg::COL_W-1:0]   cell_col_o,
  input logic                        frame_end_o,
  input logic                        run_last_o
);

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_class_o)
      && $stable(cell_row_o) && $stable(cell_col_o))
    else $error("result dropped or changed while stalled");

  // only defined class codes leave the block
  a_class_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cell_class_o == cnm_pkg::CLS_EMPTY)
      || (cell_class_o == cnm_pkg::CLS_BLOCKER)
      || (cell_class_o == cnm_pkg::CLS_MARKED))
    else $error("undefined cell class");

  // the frame's final cell closes its request's run
  a_frame_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> run_last_o)
    else $error("frame end without run last");

  // the final cell of a square grid sits on the diagonal
  a_frame_end_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> cell_row_o == cell_col_o)
    else $error("frame end off the diagonal");

  // no cell or register write is taken while a flush result is pending
  a_flush_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> !in_ready_o && !cfg_ready_o)
    else $error("request taken during last row flush");

endmodule

bind cross_neighbor_marker_unit cnm_checker u_cnm_checker (.*);

@@ dv/tb.sv @@
// testbench for cross_neighbor_marker_unit: directed table, random frames, class prediction
`timescale 1ns / 100ps

module tb;

  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int NUM_DIR       = 28;
  localparam int PHASE_CELLS   = 120;
  localparam int TAIL_CELLS    = 40;
  localparam int MAX_GRID      = cnm_pkg::MAX_SIDE_DEF;

  // one classified cell as it leaves the block
  typedef struct packed {
    cnm_pkg::cnm_class_e       cls;
    logic [cnm_pkg::ROW_W-1:0] row;
    logic [cnm_pkg::COL_W-1:0] col;
    logic                      fe;
    logic                      rl;
  } cell_result_t;

  // one row of the directed stimulus
  typedef struct packed {
    logic                       is_cfg;
    logic [cnm_pkg::SIDE_W-1:0] side;
    logic                       marked;
    logic                       typed;
    cell_result_t               want;
  } dir_row_t;

  localparam cell_result_t NO_RESULT = '{cnm_pkg::CLS_EMPTY, 5'd0, 5'd0, 1'b0, 1'b0};

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic                         is_marked_i = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [cnm_pkg::SIDE_W-1:0]   cfg_grid_side_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [cnm_pkg::CLASS_W-1:0]  cell_class_o;
  logic [cnm_pkg::ROW_W-1:0]    cell_row_o;
  logic [cnm_pkg::COL_W-1:0]    cell_col_o;
  logic                         frame_end_o;
  logic                         run_last_o;

  // predictor state
  logic [cnm_pkg::SIDE_W-1:0]   grid_side_cfg = cnm_pkg::SIDE_RESET;
  logic [MAX_GRID-1:0]          row_above2 = '0;
  logic [MAX_GRID-1:0]          row_above = '0;
  logic [MAX_GRID-1:0]          row_fill = '0;
  int                           row_pos = 0;
  int                           col_pos = 0;
  cell_result_t                 cells_due [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int cells_sent = 0;
  int results_seen = 0;
  int frames_seen = 0;
  int side_writes = 0;
  dir_row_t dir_rows [0:NUM_DIR-1];

  cross_neighbor_marker_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .is_marked_i     (is_marked_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_grid_side_i (cfg_grid_side_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cell_class_o    (cell_class_o),
    .cell_row_o      (cell_row_o),
    .cell_col_o      (cell_col_o),
    .frame_end_o     (frame_end_o),
    .run_last_o      (run_last_o)
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // side actually used: zero acts as one, large values clamp
  function automatic int side_used(input logic [cnm_pkg::SIDE_W-1:0] side);
    if (side == 0) return 1;
    if (side > MAX_GRID) return MAX_GRID;
    return int'(side);
  endfunction

  function automatic void clear_rows();
    row_above2 = '0;
    row_above  = '0;
    row_fill   = '0;
    row_pos    = 0;
    col_pos    = 0;
  endfunction

  // class of column c in the middle row, given its vertical neighbors
  function automatic cnm_pkg::cnm_class_e class_of(input logic [MAX_GRID-1:0] up,
                                                   input logic [MAX_GRID-1:0] mid,
                                                   input logic [MAX_GRID-1:0] down,
                                                   input int c, input int n);
    logic near;
    if (mid[c]) return cnm_pkg::CLS_MARKED;
    near = up[c] | down[c];
    if (c > 0) near = near | mid[c-1];
    if (c + 1 < n) near = near | mid[c+1];
    return near ? cnm_pkg::CLS_BLOCKER : cnm_pkg::CLS_EMPTY;
  endfunction

  // take one cell into the predicted grid, queue the classes it releases
  function automatic void advance_grid(input logic marked, input logic keep);
    int           n;
    int           r;
    int           c;
    logic         flush;
    cell_result_t res;
    n = side_used(grid_side_cfg);
    r = row_pos;
    c = col_pos;
    flush = (c + 1 >= n) && (r + 1 >= n);
    if (marked) row_fill[c] = 1'b1;
    if (r >= 1) begin
      res = '{class_of(row_above2, row_above, row_fill, c, n),
              cnm_pkg::ROW_W'(r - 1), cnm_pkg::COL_W'(c), 1'b0, !flush};
      if (keep) cells_due.push_back(res);
    end
    if (c + 1 >= n) begin
      if (flush) begin
        for (int k = 0; k < n; k++) begin
          res = '{class_of(row_above, row_fill, '0, k, n),
                  cnm_pkg::ROW_W'(r), cnm_pkg::COL_W'(k), k + 1 == n, k + 1 == n};
          if (keep) cells_due.push_back(res);
        end
        clear_rows();
      end else begin
        row_above2 = row_above;
        row_above  = row_fill;
        row_fill   = '0;
        col_pos    = 0;
        row_pos    = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // one cell request, with an optional idle gap before it
  task automatic send_cell(input logic marked, input logic typed, input cell_result_t want);
    int gap;
    @(negedge clk_i);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    is_marked_i <= marked;
    do @(posedge clk_i); while (!in_ready_o);
    advance_grid(marked, !typed);
    if (typed) cells_due.push_back(want);
    cells_sent++;
  endtask

  // grid_side write, only once the block has drained
  task automatic write_side(input logic [cnm_pkg::SIDE_W-1:0] side);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_grid_side_i <= side;
    do @(posedge clk_i); while (!cfg_ready_o);
    grid_side_cfg = side;
    clear_rows();
    side_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random frames: mostly whole frames, some cut short by a new side
  task automatic run_phase(input int tx_pct, input int rx_pct, input int quota);
    int                         sent;
    int                         pick;
    int                         n;
    int                         span;
    int                         dens;
    logic                       whole;
    logic                       open;
    logic [cnm_pkg::SIDE_W-1:0] side;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    open = 1'b1;
    side = grid_side_cfg;
    while (sent < quota) begin
      pick  = $urandom_range(99);
      whole = 1'b1;
      if (pick < 8) side = 6'd0;
      else if (pick < 16) side = 6'd1;
      else if (pick < 22) begin
        side  = (pick < 19) ? 6'd32 : 6'd63;
        whole = 1'b0;
      end else if (pick < 85 || open) side = cnm_pkg::SIDE_W'($urandom_range(2, 9));
      if (open || $urandom_range(3) != 0) write_side(side);
      else side = grid_side_cfg;
      n = side_used(side);
      if (!whole) span = $urandom_range(n + 1, 3 * n);
      else if (n > 1 && $urandom_range(9) == 0) begin
        span  = $urandom_range(1, n * n - 1);
        whole = 1'b0;
      end else span = n * n;
      // keep the phase within its cell budget
      if (span > quota - sent) begin
        span  = quota - sent;
        whole = 1'b0;
      end
      open = !whole;
      dens = $urandom_range(100);
      repeat (span) send_cell($urandom_range(99) < dens, 1'b0, NO_RESULT);
      sent += span;
    end
  endtask

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result check against the oldest predicted class
  always @(posedge clk_i) begin
    cell_result_t got;
    cell_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{cnm_pkg::cnm_class_e'(cell_class_o), cell_row_o, cell_col_o,
              frame_end_o, run_last_o};
      results_seen++;
      if (frame_end_o) frames_seen++;
      if (cells_due.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result class=%0d row=%0d col=%0d end=%0b last=%0b",
                 $time, got.cls, got.row, got.col, got.fe, got.rl);
      end else begin
        want = cells_due.pop_front();
        if (got.cls !== want.cls || got.row !== want.row || got.col !== want.col ||
            got.fe !== want.fe || got.rl !== want.rl) begin
          err_cnt++;
          $display("%0t: mismatch exp class=%0d row=%0d col=%0d end=%0b last=%0b",
                   $time, want.cls, want.row, want.col, want.fe, want.rl);
          $display("%0t:          got class=%0d row=%0d col=%0d end=%0b last=%0b",
                   $time, got.cls, got.row, got.col, got.fe, got.rl);
        end
      end
    end
  end

  // main sequence
  initial begin
    dir_rows = '{
      // row 0 at the reset side, no results
      '{1'b0, 6'd0,  1'b1, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b1, 1'b0, NO_RESULT},
      // one-cell grid, every cell is a whole frame
      '{1'b1, 6'd1,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b1, 1'b1, '{cnm_pkg::CLS_MARKED, 5'd0, 5'd0, 1'b1, 1'b1}},
      '{1'b0, 6'd0,  1'b0, 1'b1, '{cnm_pkg::CLS_EMPTY,  5'd0, 5'd0, 1'b1, 1'b1}},
      // side zero acts as one
      '{1'b1, 6'd0,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b1, 1'b1, '{cnm_pkg::CLS_MARKED, 5'd0, 5'd0, 1'b1, 1'b1}},
      // two by two with the corner marked
      '{1'b1, 6'd2,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b1, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT},
      // three by three cut short by a new side write
      '{1'b1, 6'd3,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b1, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b1, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT},
      // center marked, a cross of blockers around it
      '{1'b1, 6'd3,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b1, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT},
      '{1'b0, 6'd0,  1'b0, 1'b0, NO_RESULT}
    };

    // reset
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    tx_idle_pct = 14;
    rx_idle_pct = 66;
    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].is_cfg) write_side(dir_rows[i].side);
      else send_cell(dir_rows[i].marked, dir_rows[i].typed, dir_rows[i].want);
    end

    // random frames under changing stall patterns
    run_phase(14, 66, PHASE_CELLS);
    run_phase(66, 14, PHASE_CELLS);

    // long receiver hold-off while cells keep coming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_side(6'd5);
    hold_asked++;
    repeat (25) send_cell($urandom_range(1), 1'b0, NO_RESULT);
    run_phase(0, 0, PHASE_CELLS);

    // first rows of a frame at a side written out of range
    write_side(6'd63);
    repeat (TAIL_CELLS) send_cell($urandom_range(2) == 0, 1'b0, NO_RESULT);

    // drain
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d cells over %0d side writes, checked %0d classes in %0d frames",
             cells_sent, side_writes, results_seen, frames_seen);
    $display("sides from 0 to 63, random stalls on both channels, one long output hold-off");
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
